// ===== rtl/lbgk_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbgk_pkg: shared types, constants and functions
// Word types, D2Q9 direction tables, weights and saturation for the BGK core.
// ----------------------------------------------------------------------------
package lbgk_pkg;

	localparam int DIRS          = 9;
	localparam int FRAC_BITS_DEF = 24;
	localparam int WORD_W        = 32;
	localparam int RATE_W        = 26;
	localparam int QUO_BITS      = 32;
	localparam int LANE_LAT      = 6;

	localparam logic [RATE_W-1:0] RATE_RESET = 26'd8388608;

	typedef logic signed [WORD_W-1:0] word_t;
	typedef logic signed [63:0]       wide_t;

	localparam wide_t WORD_MAX = 64'sd2147483647;
	localparam wide_t WORD_MIN = -64'sd2147483648;

	// Lattice velocities in the usual order, rest first.
	localparam logic signed [1:0] DIR_X [DIRS] =
		'{2'sd0, 2'sd1, 2'sd0, -2'sd1, 2'sd0, 2'sd1, -2'sd1, -2'sd1, 2'sd1};
	localparam logic signed [1:0] DIR_Y [DIRS] =
		'{2'sd0, 2'sd0, 2'sd1, 2'sd0, -2'sd1, 2'sd1, 2'sd1, -2'sd1, -2'sd1};

	// One result word leaving the core.
	typedef struct packed {
		logic [DIRS-1:0][WORD_W-1:0] new_pop;
		word_t                       density;
		word_t                       velocity_x;
		word_t                       velocity_y;
	} out_word_t;

	// Clamp a wide value to the signed word range.
	function automatic word_t sat32(input wide_t v);
		word_t r;
		if (v > WORD_MAX) begin
			r = word_t'(WORD_MAX);
		end else if (v < WORD_MIN) begin
			r = word_t'(WORD_MIN);
		end else begin
			r = word_t'(v);
		end
		return r;
	endfunction

	// Lattice weight of a direction, rounded to nearest at fb fraction bits.
	function automatic wide_t weight_of(input int k, input int fb);
		wide_t one;
		wide_t w;
		one = 64'sd1 <<< fb;
		if (k == 0) begin
			w = (4 * one + 64'sd4) / 9;
		end else if (k <= 4) begin
			w = (one + 64'sd4) / 9;
		end else begin
			w = (one + 64'sd18) / 36;
		end
		return w;
	endfunction

endpackage

// ===== rtl/lbgk_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbgk_if: stream channels of the collision core
// Cell input channel and result output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface lbgk_in_if;
	import lbgk_pkg::*;

	logic  valid;
	logic  ready;
	word_t pop_0;
	word_t pop_1;
	word_t pop_2;
	word_t pop_3;
	word_t pop_4;
	word_t pop_5;
	word_t pop_6;
	word_t pop_7;
	word_t pop_8;

	modport source (output valid, pop_0, pop_1, pop_2, pop_3, pop_4, pop_5, pop_6,
		pop_7, pop_8, input ready);
	modport sink (input valid, pop_0, pop_1, pop_2, pop_3, pop_4, pop_5, pop_6,
		pop_7, pop_8, output ready);
endinterface

interface lbgk_out_if;
	import lbgk_pkg::*;

	logic  valid;
	logic  ready;
	word_t new_pop_0;
	word_t new_pop_1;
	word_t new_pop_2;
	word_t new_pop_3;
	word_t new_pop_4;
	word_t new_pop_5;
	word_t new_pop_6;
	word_t new_pop_7;
	word_t new_pop_8;
	word_t density;
	word_t velocity_x;
	word_t velocity_y;

	modport source (output valid, new_pop_0, new_pop_1, new_pop_2, new_pop_3,
		new_pop_4, new_pop_5, new_pop_6, new_pop_7, new_pop_8, density,
		velocity_x, velocity_y, input ready);
	modport sink (input valid, new_pop_0, new_pop_1, new_pop_2, new_pop_3,
		new_pop_4, new_pop_5, new_pop_6, new_pop_7, new_pop_8, density,
		velocity_x, velocity_y, output ready);
endinterface

// ===== rtl/lbgk_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbgk_div: pipelined momentum over density divider
// Restoring division, one quotient bit per stage, truncated toward zero and
// saturated; a density that is not positive gives zero.
// ----------------------------------------------------------------------------
module lbgk_div #(
	parameter int FRACTION_BITS = lbgk_pkg::FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 en,
	input  lbgk_pkg::wide_t      num,
	input  lbgk_pkg::word_t      den,
	output lbgk_pkg::word_t      quo
);
	import lbgk_pkg::*;

	localparam int QB = QUO_BITS;

	wide_t       num_sh;
	logic        num_neg;
	logic [63:0] num_abs;

	logic              neg_s [0:QB];
	logic              pos_s [0:QB];
	logic              ovf_s [0:QB];
	logic [30:0]       den_s [0:QB];
	logic [30:0]       rem_s [0:QB];
	logic [QB-1:0]     low_s [0:QB];
	logic [QB-1:0]     quo_s [0:QB];
	word_t             quo_q;

	// Scale the momentum and take its magnitude.
	always_comb begin
		num_sh  = num <<< FRACTION_BITS;
		num_neg = num_sh[63];
		num_abs = num_neg ? 64'(-num_sh) : 64'(num_sh);
	end

	// Entry stage: sign, overflow check and first partial remainder.
	always_ff @(posedge clk) begin
		if (en) begin
			neg_s[0] <= num_neg;
			pos_s[0] <= (den > 0);
			ovf_s[0] <= (num_abs[63:QB] >= {{(QB-31){1'b0}}, den[30:0]});
			den_s[0] <= den[30:0];
			rem_s[0] <= num_abs[QB+30:QB];
			low_s[0] <= num_abs[QB-1:0];
			quo_s[0] <= '0;
		end
	end

	// One compare and subtract per stage, most significant bit first.
	for (genvar j = 0; j < QB; j++) begin : g_step
		localparam int B = QB - 1 - j;
		logic [31:0]   trial;
		logic          ge;
		logic [31:0]   diff;
		logic [QB-1:0] qnext;

		always_comb begin
			trial    = {rem_s[j], low_s[j][B]};
			ge       = trial >= {1'b0, den_s[j]};
			diff     = trial - {1'b0, den_s[j]};
			qnext    = quo_s[j];
			qnext[B] = ge;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				neg_s[j+1] <= neg_s[j];
				pos_s[j+1] <= pos_s[j];
				ovf_s[j+1] <= ovf_s[j];
				den_s[j+1] <= den_s[j];
				low_s[j+1] <= low_s[j];
				rem_s[j+1] <= ge ? diff[30:0] : trial[30:0];
				quo_s[j+1] <= qnext;
			end
		end
	end

	// Apply the sign and saturate.
	always_ff @(posedge clk) begin
		if (en) begin
			if (!pos_s[QB]) begin
				quo_q <= '0;
			end else if (ovf_s[QB]) begin
				quo_q <= neg_s[QB] ? word_t'(WORD_MIN) : word_t'(WORD_MAX);
			end else if (neg_s[QB]) begin
				quo_q <= sat32(-wide_t'({32'd0, quo_s[QB]}));
			end else begin
				quo_q <= sat32(wide_t'({32'd0, quo_s[QB]}));
			end
		end
	end

	assign quo = quo_q;

endmodule

// ===== rtl/lbgk_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbgk_lane: equilibrium and relaxation for one lattice direction
// Six stage pipeline: projection, square, polynomial, equilibrium, products,
// relaxed sum.
// ----------------------------------------------------------------------------
module lbgk_lane #(
	parameter int FRACTION_BITS = lbgk_pkg::FRAC_BITS_DEF,
	parameter int K             = 0
) (
	input  logic                          clk,
	input  logic                          en,
	input  lbgk_pkg::word_t               ux,
	input  lbgk_pkg::word_t               uy,
	input  lbgk_pkg::word_t               rho,
	input  lbgk_pkg::word_t               f,
	input  lbgk_pkg::word_t               sq,
	input  logic [lbgk_pkg::RATE_W-1:0]   omega,
	output lbgk_pkg::word_t               new_f
);
	import lbgk_pkg::*;

	localparam wide_t ONE = 64'sd1 <<< FRACTION_BITS;
	localparam wide_t WGT = weight_of(K, FRACTION_BITS);
	localparam wide_t EX  = wide_t'(DIR_X[K]);
	localparam wide_t EY  = wide_t'(DIR_Y[K]);

	word_t dot_s1, wr_s1, f_s1;
	word_t dot_s2, d2_s2, wr_s2, f_s2;
	word_t poly_s3, wr_s3, f_s3;
	word_t eq_s4, f_s4;
	wide_t pa_s5, pb_s5;
	word_t nf_s6;

	wide_t om_w;
	wide_t poly_w;

	always_comb begin
		om_w   = wide_t'({38'd0, omega});
		poly_w = ONE + 3 * wide_t'(dot_s2) + ((9 * wide_t'(d2_s2)) >>> 1)
			- ((3 * wide_t'(sq)) >>> 1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// Projection of velocity on the direction, and weighted density.
			dot_s1  <= sat32(EX * wide_t'(ux) + EY * wide_t'(uy));
			wr_s1   <= sat32((WGT * wide_t'(rho)) >>> FRACTION_BITS);
			f_s1    <= f;
			// Square of the projection.
			d2_s2   <= sat32((wide_t'(dot_s1) * wide_t'(dot_s1)) >>> FRACTION_BITS);
			dot_s2  <= dot_s1;
			wr_s2   <= wr_s1;
			f_s2    <= f_s1;
			// Equilibrium polynomial.
			poly_s3 <= sat32(poly_w);
			wr_s3   <= wr_s2;
			f_s3    <= f_s2;
			// Equilibrium population.
			eq_s4   <= sat32((wide_t'(wr_s3) * wide_t'(poly_s3)) >>> FRACTION_BITS);
			f_s4    <= f_s3;
			// Both relaxation products, shifted but not clamped.
			pa_s5   <= (wide_t'(f_s4) * (ONE - om_w)) >>> FRACTION_BITS;
			pb_s5   <= (om_w * wide_t'(eq_s4)) >>> FRACTION_BITS;
			// Relaxed population.
			nf_s6   <= sat32(pa_s5 + pb_s5);
		end
	end

	assign new_f = nf_s6;

endmodule

// ===== rtl/lattice_boltzmann_d2q9_collision_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lattice_boltzmann_d2q9_collision_core: D2Q9 BGK collision, one cell a cycle
// while not stalled. Moments, pipelined division for velocity, nine
// direction lanes and an output stage with a skid word.
// ----------------------------------------------------------------------------
// The core takes one cell word (nine populations) per clock while ready is
// high and returns one result word per cell in order. Each cell passes the
// velocity divider, which resolves one quotient bit per stage over 32
// stages, followed by six lane stages.
// A skid word at the output lets the core accept one more cell while a
// result waits; ready is registered. relax_rate may only be written while
// no cell is in flight.
module lattice_boltzmann_d2q9_collision_core #(
	parameter int FRACTION_BITS = lbgk_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	lbgk_in_if.sink                       cell_in,
	lbgk_out_if.source                    cell_out,
	input  logic                          cfg_we,
	input  logic [lbgk_pkg::RATE_W-1:0]   cfg_wdata
);
	import lbgk_pkg::*;

	localparam int DIV_LAT = QUO_BITS + 2;
	localparam int NSTG    = 2 + DIV_LAT + LANE_LAT;

	logic [RATE_W-1:0] rate_q;
	logic              en;
	logic [NSTG-1:0]   vld_s;
	logic              skid_v_q;
	out_word_t         skid_q;
	out_word_t         last_w;
	out_word_t         out_w;

	word_t pop_in [DIRS];
	word_t pop_s1 [DIRS];
	word_t pop_s2 [DIRS];
	word_t rho_s2;
	wide_t mx_s2, my_s2;
	wide_t sum_w, mx_w, my_w;

	word_t pop_d_s [0:DIV_LAT-1][DIRS];
	word_t rho_d_s [0:DIV_LAT-1];
	word_t ux, uy;

	logic [63:0] pxx_s1, pyy_s1;
	logic [63:0] sq_sum;
	word_t       sq_s2;

	word_t rho_o_s [0:LANE_LAT-1];
	word_t ux_o_s  [0:LANE_LAT-1];
	word_t uy_o_s  [0:LANE_LAT-1];
	word_t new_f   [DIRS];

	// Relaxation rate register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= RATE_RESET;
		end else if (cfg_we) begin
			rate_q <= cfg_wdata;
		end
	end

	// The whole pipeline moves unless the skid word is occupied.
	assign en            = !skid_v_q;
	assign cell_in.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[NSTG-2:0], cell_in.valid};
		end
	end

	always_comb begin
		pop_in[0] = cell_in.pop_0;
		pop_in[1] = cell_in.pop_1;
		pop_in[2] = cell_in.pop_2;
		pop_in[3] = cell_in.pop_3;
		pop_in[4] = cell_in.pop_4;
		pop_in[5] = cell_in.pop_5;
		pop_in[6] = cell_in.pop_6;
		pop_in[7] = cell_in.pop_7;
		pop_in[8] = cell_in.pop_8;
	end

	// Density and momentum sums.
	always_comb begin
		sum_w = '0;
		mx_w  = '0;
		my_w  = '0;
		for (int k = 0; k < DIRS; k++) begin
			sum_w = sum_w + wide_t'(pop_s1[k]);
			mx_w  = mx_w + wide_t'(DIR_X[k]) * wide_t'(pop_s1[k]);
			my_w  = my_w + wide_t'(DIR_Y[k]) * wide_t'(pop_s1[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pop_s1 <= pop_in;
			pop_s2 <= pop_s1;
			rho_s2 <= sat32(sum_w);
			mx_s2  <= mx_w;
			my_s2  <= my_w;
		end
	end

	// Velocity dividers.
	lbgk_div #(.FRACTION_BITS(FRACTION_BITS)) u_div_x (
		.clk (clk), .en (en), .num (mx_s2), .den (rho_s2), .quo (ux)
	);

	lbgk_div #(.FRACTION_BITS(FRACTION_BITS)) u_div_y (
		.clk (clk), .en (en), .num (my_s2), .den (rho_s2), .quo (uy)
	);

	// Carry populations and density alongside the dividers.
	always_ff @(posedge clk) begin
		if (en) begin
			pop_d_s[0] <= pop_s2;
			rho_d_s[0] <= rho_s2;
			for (int i = 1; i < DIV_LAT; i++) begin
				pop_d_s[i] <= pop_d_s[i-1];
				rho_d_s[i] <= rho_d_s[i-1];
			end
		end
	end

	// Squared speed, shared by all lanes.
	always_comb begin
		sq_sum = (pxx_s1 + pyy_s1) >> FRACTION_BITS;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pxx_s1 <= 64'(wide_t'(ux) * wide_t'(ux));
			pyy_s1 <= 64'(wide_t'(uy) * wide_t'(uy));
			sq_s2  <= (sq_sum > 64'(WORD_MAX)) ? word_t'(WORD_MAX) : word_t'(sq_sum);
		end
	end

	// Direction lanes.
	for (genvar k = 0; k < DIRS; k++) begin : g_lane
		lbgk_lane #(.FRACTION_BITS(FRACTION_BITS), .K(k)) u_lane (
			.clk   (clk),
			.en    (en),
			.ux    (ux),
			.uy    (uy),
			.rho   (rho_d_s[DIV_LAT-1]),
			.f     (pop_d_s[DIV_LAT-1][k]),
			.sq    (sq_s2),
			.omega (rate_q),
			.new_f (new_f[k])
		);
	end

	// Density and velocity follow the lanes to the output.
	always_ff @(posedge clk) begin
		if (en) begin
			rho_o_s[0] <= rho_d_s[DIV_LAT-1];
			ux_o_s[0]  <= ux;
			uy_o_s[0]  <= uy;
			for (int i = 1; i < LANE_LAT; i++) begin
				rho_o_s[i] <= rho_o_s[i-1];
				ux_o_s[i]  <= ux_o_s[i-1];
				uy_o_s[i]  <= uy_o_s[i-1];
			end
		end
	end

	// Merge the lane results into one result word.
	always_comb begin
		for (int k = 0; k < DIRS; k++) begin
			last_w.new_pop[k] = new_f[k];
		end
		last_w.density    = rho_o_s[LANE_LAT-1];
		last_w.velocity_x = ux_o_s[LANE_LAT-1];
		last_w.velocity_y = uy_o_s[LANE_LAT-1];
	end

	// Skid word: catches the last stage when the output stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (cell_out.ready) begin
				skid_v_q <= 1'b0;
			end
		end else if (vld_s[NSTG-1] && !cell_out.ready) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			skid_q <= last_w;
		end
	end

	assign out_w          = skid_v_q ? skid_q : last_w;
	assign cell_out.valid = skid_v_q || vld_s[NSTG-1];

	assign cell_out.new_pop_0  = word_t'(out_w.new_pop[0]);
	assign cell_out.new_pop_1  = word_t'(out_w.new_pop[1]);
	assign cell_out.new_pop_2  = word_t'(out_w.new_pop[2]);
	assign cell_out.new_pop_3  = word_t'(out_w.new_pop[3]);
	assign cell_out.new_pop_4  = word_t'(out_w.new_pop[4]);
	assign cell_out.new_pop_5  = word_t'(out_w.new_pop[5]);
	assign cell_out.new_pop_6  = word_t'(out_w.new_pop[6]);
	assign cell_out.new_pop_7  = word_t'(out_w.new_pop[7]);
	assign cell_out.new_pop_8  = word_t'(out_w.new_pop[8]);
	assign cell_out.density    = out_w.density;
	assign cell_out.velocity_x = out_w.velocity_x;
	assign cell_out.velocity_y = out_w.velocity_y;

`ifndef NO_ASSERTIONS
	// The skid word fills only when a result was offered and refused.
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_v_q) |-> $past(vld_s[NSTG-1] && !cell_out.ready))
		else $error("skid word filled without a stalled result");

	// A density that is not positive leaves the velocity at zero.
	a_zero_vel: assert property (@(posedge clk) disable iff (!arst_n)
		(cell_out.valid && cell_out.density <= 0) |->
		(cell_out.velocity_x == 0 && cell_out.velocity_y == 0))
		else $error("nonzero velocity with nonpositive density");

	// A held result word does not change while it waits.
	a_skid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_v_q && $past(skid_v_q)) |-> $stable(skid_q))
		else $error("skid word changed while occupied");
`endif

endmodule
